// ===== sv/ppmp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmp_pkg
// shared types and character codes for the p6 stream parser
// ----------------------------------------------------------------------------
package ppmp_pkg;

	typedef enum logic [1:0] {
		PH_MAGIC   = 2'd0,
		PH_NUMBERS = 2'd1,
		PH_PIXELS  = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MG_NONE = 2'd0,
		MG_P    = 2'd1,
		MG_P6   = 2'd2,
		MG_BAD  = 2'd3
	} magic_t;

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_PIX = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_HDR_TRUNC = 3'd2;
	localparam logic [2:0] ERR_NUMBER    = 3'd3;
	localparam logic [2:0] ERR_PIX_TRUNC = 3'd4;

	localparam logic [1:0] FIELD_WIDTH  = 2'd0;
	localparam logic [1:0] FIELD_HEIGHT = 2'd1;
	localparam logic [1:0] FIELD_MAXVAL = 2'd2;

	localparam logic [1:0] CHAN_RED  = 2'd0;
	localparam logic [1:0] CHAN_BLUE = 2'd2;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int MAXVAL_LIM = 255;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pixel_data;
		logic [1:0]  channel;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  max_value;
		logic [2:0]  error_code;
		logic        last_pixel;
	} res_t;

endpackage

// ===== sv/ppm_p6_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser
// binary ppm (p6) byte stream parser with header check and pixel output
// ----------------------------------------------------------------------------
// s_axis carries the file one byte per word; s_axis_tuser high marks the end
// of the file and the byte is then ignored. m_axis gives at most one word
// per input word: a header word with width, height and maxval, then one
// word per pixel byte tagged with its channel (tlast on the final byte), or
// a single error word. after an error, the final pixel or an end of file
// every further byte is taken and dropped until reset.
// an accepted byte lands in an input register and is parsed from there
// into the output register once that register is free. one byte per
// cycle is sustained while m_axis_tready stays high; the combinational
// tokeniser and digit accumulator set that figure.
// reset returns to waiting for the magic token with no output pending.
// when m_axis_tready is low the output word holds, one more byte is held in
// the input register and s_axis_tready then drops.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser #(
	parameter int DIM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tuser,   // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // pixel_data, image_width, image_height, max_value,
	                                    // error_code, zero fill
	output logic [3:0]  m_axis_tuser,   // kind, channel
	output logic        m_axis_tlast    // last_pixel
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;
	logic            out_free;
	logic            step;
	logic            core_valid;
	ppmp_pkg::res_t  core_res;
	logic            out_valid_q;
	ppmp_pkg::res_t  out_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	ppmp_parse_core #(
		.DIM_BITS(DIM_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.in_byte    (byte_s1),
		.stream_end (end_s1),
		.res_valid  (core_valid),
		.res        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && core_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			out_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.error_code, out_q.max_value, out_q.image_height,
		out_q.image_width, out_q.pixel_data};
	assign m_axis_tuser  = {out_q.channel, out_q.kind};
	assign m_axis_tlast  = out_q.last_pixel;

endmodule

// ===== sv/ppmp_parse_core.sv =====
// ----------------------------------------------------------------------------
// ppmp_parse_core
// per-byte header tokeniser, number accumulator and pixel sequencer
// ----------------------------------------------------------------------------
module ppmp_parse_core #(
	parameter int DIM_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_byte,
	input  logic             stream_end,
	output logic             res_valid,
	output ppmp_pkg::res_t   res
);

	localparam int ACC_W  = DIM_BITS + 1;
	localparam int PROD_W = DIM_BITS + 5;
	localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);

	ppmp_pkg::phase_t      phase_q, phase_d;
	ppmp_pkg::magic_t      magic_q, magic_d;
	logic [1:0]            field_q, field_d;
	logic                  in_comment_q, in_comment_d;
	logic                  in_token_q, in_token_d;
	logic                  digits_done_q, digits_done_d;
	logic [ACC_W-1:0]      accum_q, accum_d;
	logic [DIM_BITS-1:0]   width_q, width_d;
	logic [DIM_BITS-1:0]   height_q, height_d;
	logic [7:0]            maxval_q, maxval_d;
	logic                  cr_q, cr_d;
	logic [1:0]            chan_q, chan_d;
	logic [DIM_BITS-1:0]   col_q, col_d;
	logic [DIM_BITS-1:0]   row_q, row_d;

	logic                  is_space;
	logic                  is_digit;
	logic [ACC_W-1:0]      lim;
	logic [ACC_W-1:0]      lim_sat;
	logic [PROD_W-1:0]     prod;
	logic [ACC_W-1:0]      accum_next;
	logic [ACC_W-1:0]      value;
	logic                  tok_end;
	logic                  col_last;
	logic                  row_last;
	logic                  pix_last;

	assign is_space = (in_byte == ppmp_pkg::CH_SPACE) || (in_byte == ppmp_pkg::CH_TAB) ||
		(in_byte == ppmp_pkg::CH_LF) || (in_byte == ppmp_pkg::CH_CR);
	assign is_digit = (in_byte >= ppmp_pkg::CH_ZERO) && (in_byte <= ppmp_pkg::CH_NINE);

	// limit of the current field, saturating value one above it
	assign lim = (field_q >= ppmp_pkg::FIELD_MAXVAL) ? ACC_W'(ppmp_pkg::MAXVAL_LIM) :
		{1'b0, {DIM_BITS{1'b1}}};
	assign lim_sat = lim + ACC_W'(1);
	assign prod = (PROD_W'(accum_q) << 3) + (PROD_W'(accum_q) << 1) + PROD_W'(in_byte[3:0]);
	assign accum_next = (prod > PROD_W'(lim)) ? lim_sat : prod[ACC_W-1:0];
	assign value = ((accum_q == '0) || (accum_q > lim)) ? '0 : accum_q;

	assign tok_end = in_token_q && (stream_end || (!in_comment_q && is_space));

	assign col_last = (col_q == (width_q - DIM_ONE));
	assign row_last = (row_q == (height_q - DIM_ONE));
	assign pix_last = (chan_q == ppmp_pkg::CHAN_BLUE) && col_last && row_last;

	always_comb begin
		phase_d       = phase_q;
		magic_d       = magic_q;
		field_d       = field_q;
		in_comment_d  = in_comment_q;
		in_token_d    = in_token_q;
		digits_done_d = digits_done_q;
		accum_d       = accum_q;
		width_d       = width_q;
		height_d      = height_q;
		maxval_d      = maxval_q;
		cr_d          = cr_q;
		chan_d        = chan_q;
		col_d         = col_q;
		row_d         = row_q;
		res_valid     = 1'b0;
		res           = '0;
		case (phase_q)
			ppmp_pkg::PH_PIXELS: begin
				if (stream_end) begin
					res_valid      = 1'b1;
					res.kind       = ppmp_pkg::KIND_ERR;
					res.error_code = ppmp_pkg::ERR_PIX_TRUNC;
					phase_d        = ppmp_pkg::PH_DONE;
				end else if (cr_q && in_byte == ppmp_pkg::CH_LF) begin
					cr_d = 1'b0;
				end else begin
					cr_d           = 1'b0;
					res_valid      = 1'b1;
					res.kind       = ppmp_pkg::KIND_PIX;
					res.pixel_data = in_byte;
					res.channel    = chan_q;
					res.last_pixel = pix_last;
					if (chan_q == ppmp_pkg::CHAN_BLUE) begin
						chan_d = ppmp_pkg::CHAN_RED;
						if (col_last) begin
							col_d = '0;
							row_d = row_q + DIM_ONE;
						end else begin
							col_d = col_q + DIM_ONE;
						end
					end else begin
						chan_d = chan_q + 2'd1;
					end
					if (pix_last) begin
						phase_d = ppmp_pkg::PH_DONE;
					end
				end
			end
			ppmp_pkg::PH_MAGIC, ppmp_pkg::PH_NUMBERS: begin
				if (stream_end && !in_token_q) begin
					res_valid      = 1'b1;
					res.kind       = ppmp_pkg::KIND_ERR;
					res.error_code = ppmp_pkg::ERR_HDR_TRUNC;
					phase_d        = ppmp_pkg::PH_DONE;
				end else if (tok_end) begin
					in_token_d    = 1'b0;
					digits_done_d = 1'b0;
					accum_d       = '0;
					magic_d       = ppmp_pkg::MG_NONE;
					if (phase_q == ppmp_pkg::PH_MAGIC) begin
						if (magic_q != ppmp_pkg::MG_P6) begin
							res_valid      = 1'b1;
							res.kind       = ppmp_pkg::KIND_ERR;
							res.error_code = ppmp_pkg::ERR_MAGIC;
							phase_d        = ppmp_pkg::PH_DONE;
						end else if (stream_end) begin
							res_valid      = 1'b1;
							res.kind       = ppmp_pkg::KIND_ERR;
							res.error_code = ppmp_pkg::ERR_HDR_TRUNC;
							phase_d        = ppmp_pkg::PH_DONE;
						end else begin
							phase_d = ppmp_pkg::PH_NUMBERS;
							field_d = ppmp_pkg::FIELD_WIDTH;
						end
					end else if (field_q < ppmp_pkg::FIELD_MAXVAL) begin
						if (field_q == ppmp_pkg::FIELD_WIDTH) begin
							width_d = value[DIM_BITS-1:0];
						end else begin
							height_d = value[DIM_BITS-1:0];
						end
						if (stream_end) begin
							res_valid      = 1'b1;
							res.kind       = ppmp_pkg::KIND_ERR;
							res.error_code = ppmp_pkg::ERR_HDR_TRUNC;
							phase_d        = ppmp_pkg::PH_DONE;
						end else begin
							field_d = field_q + 2'd1;
						end
					end else begin
						maxval_d = value[7:0];
						if (width_q == '0 || height_q == '0 || value == '0) begin
							res_valid      = 1'b1;
							res.kind       = ppmp_pkg::KIND_ERR;
							res.error_code = ppmp_pkg::ERR_NUMBER;
							phase_d        = ppmp_pkg::PH_DONE;
						end else if (stream_end) begin
							res_valid      = 1'b1;
							res.kind       = ppmp_pkg::KIND_ERR;
							res.error_code = ppmp_pkg::ERR_PIX_TRUNC;
							phase_d        = ppmp_pkg::PH_DONE;
						end else begin
							res_valid        = 1'b1;
							res.kind         = ppmp_pkg::KIND_HDR;
							res.image_width  = 16'(width_q);
							res.image_height = 16'(height_q);
							res.max_value    = value[7:0];
							cr_d             = (in_byte == ppmp_pkg::CH_CR);
							chan_d           = ppmp_pkg::CHAN_RED;
							col_d            = '0;
							row_d            = '0;
							phase_d          = ppmp_pkg::PH_PIXELS;
						end
					end
				end else if (in_comment_q) begin
					if (in_byte == ppmp_pkg::CH_LF) begin
						in_comment_d = 1'b0;
					end
				end else if (!in_token_q) begin
					if (is_space) begin
						in_token_d = 1'b0;
					end else if (in_byte == ppmp_pkg::CH_HASH) begin
						in_comment_d = 1'b1;
					end else begin
						in_token_d = 1'b1;
						if (phase_q == ppmp_pkg::PH_MAGIC) begin
							magic_d = (in_byte == ppmp_pkg::CH_P) ? ppmp_pkg::MG_P :
								ppmp_pkg::MG_BAD;
						end else if (in_byte == ppmp_pkg::CH_MINUS) begin
							digits_done_d = 1'b1;
							accum_d       = '0;
						end else if (in_byte == ppmp_pkg::CH_PLUS) begin
							digits_done_d = 1'b0;
						end else if (is_digit) begin
							accum_d = accum_next;
						end else begin
							digits_done_d = 1'b1;
						end
					end
				end else begin
					// inside a token
					if (phase_q == ppmp_pkg::PH_MAGIC) begin
						magic_d = (magic_q == ppmp_pkg::MG_P && in_byte == ppmp_pkg::CH_SIX) ?
							ppmp_pkg::MG_P6 : ppmp_pkg::MG_BAD;
					end else if (!digits_done_q && is_digit) begin
						accum_d = accum_next;
					end else begin
						digits_done_d = 1'b1;
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ppmp_pkg::PH_MAGIC;
			magic_q       <= ppmp_pkg::MG_NONE;
			field_q       <= ppmp_pkg::FIELD_WIDTH;
			in_comment_q  <= 1'b0;
			in_token_q    <= 1'b0;
			digits_done_q <= 1'b0;
			accum_q       <= '0;
			width_q       <= '0;
			height_q      <= '0;
			maxval_q      <= '0;
			cr_q          <= 1'b0;
			chan_q        <= ppmp_pkg::CHAN_RED;
			col_q         <= '0;
			row_q         <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			magic_q       <= magic_d;
			field_q       <= field_d;
			in_comment_q  <= in_comment_d;
			in_token_q    <= in_token_d;
			digits_done_q <= digits_done_d;
			accum_q       <= accum_d;
			width_q       <= width_d;
			height_q      <= height_d;
			maxval_q      <= maxval_d;
			cr_q          <= cr_d;
			chan_q        <= chan_d;
			col_q         <= col_d;
			row_q         <= row_d;
		end
	end

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == ppmp_pkg::KIND_ERR |=> phase_q == ppmp_pkg::PH_DONE)
		else $error("error word did not stop the parser");

	a_hdr_starts_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == ppmp_pkg::KIND_HDR |=>
		phase_q == ppmp_pkg::PH_PIXELS && chan_q == ppmp_pkg::CHAN_RED && col_q == '0 &&
		row_q == '0)
		else $error("header word without pixel counters cleared");

	a_pix_in_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ppmp_pkg::KIND_PIX |-> phase_q == ppmp_pkg::PH_PIXELS &&
		width_q != '0 && height_q != '0 && maxval_q != '0)
		else $error("pixel word outside a valid image");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ppmp_pkg::PH_DONE |-> !res_valid)
		else $error("word produced after parsing finished");

endmodule

// ===== tb/ppm_p6_checker.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_checker
// Watches both stream channels of the p6 parser and predicts each output
// word from the accepted input bytes. Output words are compared field by
// field, in order, with the predicted words. The number of mismatches, the
// number of predicted words still due and the number of pixel words checked
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module ppm_p6_checker
	import ppmp_pkg::*;
#(
	parameter int DIM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tuser,   // stream_end
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,   // pixel_data, image_width, image_height, max_value,
	                                    // error_code, zero fill
	input  logic [3:0]  m_axis_tuser,   // kind, channel
	input  logic        m_axis_tlast,   // last_pixel
	output int          fails,
	output int          outstanding,
	output int          pixel_words
);
	timeunit 1ns;
	timeprecision 1ps;

	phase_t          ph        = PH_MAGIC;
	logic [1:0]      field_idx = FIELD_WIDTH;
	logic            in_cmt    = 1'b0;
	logic            in_tok    = 1'b0;
	logic            dig_done  = 1'b0;
	int unsigned     accum     = 0;
	magic_t          magic     = MG_NONE;
	int unsigned     width_v   = 0;
	int unsigned     height_v  = 0;
	int unsigned     maxval_v  = 0;
	logic            swallow_lf = 1'b0;
	longint unsigned bytes_due = 0;
	logic [1:0]      chan      = CHAN_RED;

	res_t expected_words [$];
	int   mismatch_cnt = 0;
	int   due_cnt      = 0;
	int   pix_cnt      = 0;

	assign fails       = mismatch_cnt;
	assign outstanding = due_cnt;
	assign pixel_words = pix_cnt;

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic int unsigned field_cap();
		return (field_idx >= FIELD_MAXVAL) ? MAXVAL_LIM : (1 << DIM_BITS) - 1;
	endfunction

	function automatic bit raise_error(logic [2:0] code, output res_t r);
		r            = '0;
		r.kind       = KIND_ERR;
		r.error_code = code;
		ph           = PH_DONE;
		return 1'b1;
	endfunction

	function automatic void take_char(logic [7:0] c, bit first);
		if (ph == PH_MAGIC) begin
			if (magic == MG_NONE && c == CH_P)
				magic = MG_P;
			else if (magic == MG_P && c == CH_SIX)
				magic = MG_P6;
			else
				magic = MG_BAD;
		end else if (!(first && c == CH_PLUS)) begin
			if (!dig_done && c >= CH_ZERO && c <= CH_NINE) begin
				accum = accum * 10 + (c - CH_ZERO);
				if (accum > field_cap())
					accum = field_cap() + 1;
			end else begin
				dig_done = 1'b1;
			end
		end
	endfunction

	function automatic bit close_token(bit eof, bit cr, output res_t r);
		int unsigned v;
		bit          magic_ok;
		r        = '0;
		magic_ok = magic == MG_P6;
		v        = (accum == 0 || accum > field_cap()) ? 0 : accum;
		in_tok   = 1'b0;
		dig_done = 1'b0;
		accum    = 0;
		magic    = MG_NONE;
		if (ph == PH_MAGIC) begin
			if (!magic_ok)
				return raise_error(ERR_MAGIC, r);
			if (eof)
				return raise_error(ERR_HDR_TRUNC, r);
			ph        = PH_NUMBERS;
			field_idx = FIELD_WIDTH;
			return 1'b0;
		end
		case (field_idx)
			FIELD_WIDTH:  width_v  = v;
			FIELD_HEIGHT: height_v = v;
			default:      maxval_v = v;
		endcase
		if (field_idx < FIELD_MAXVAL) begin
			if (eof)
				return raise_error(ERR_HDR_TRUNC, r);
			field_idx = field_idx + 2'd1;
			return 1'b0;
		end
		if (width_v == 0 || height_v == 0 || maxval_v == 0)
			return raise_error(ERR_NUMBER, r);
		if (eof)
			return raise_error(ERR_PIX_TRUNC, r);
		r.kind         = KIND_HDR;
		r.image_width  = width_v[15:0];
		r.image_height = height_v[15:0];
		r.max_value    = maxval_v[7:0];
		bytes_due      = longint'(width_v) * longint'(height_v) * 3;
		swallow_lf     = cr;
		chan           = CHAN_RED;
		ph             = PH_PIXELS;
		return 1'b1;
	endfunction

	// returns 1 when the byte causes an output word
	function automatic bit parse_ppm_byte(logic [7:0] b, logic eof, output res_t r);
		r = '0;
		if (ph == PH_DONE)
			return 1'b0;
		if (ph == PH_PIXELS) begin
			if (eof)
				return raise_error(ERR_PIX_TRUNC, r);
			if (swallow_lf) begin
				swallow_lf = 1'b0;
				if (b == CH_LF)
					return 1'b0;
			end
			r.kind       = KIND_PIX;
			r.pixel_data = b;
			r.channel    = chan;
			r.last_pixel = bytes_due == 1;
			chan         = (chan >= CHAN_BLUE) ? CHAN_RED : chan + 2'd1;
			if (bytes_due > 0)
				bytes_due--;
			if (bytes_due == 0)
				ph = PH_DONE;
			return 1'b1;
		end
		if (eof) begin
			if (!in_tok)
				return raise_error(ERR_HDR_TRUNC, r);
			return close_token(1'b1, 1'b0, r);
		end
		if (in_cmt) begin
			if (b == CH_LF)
				in_cmt = 1'b0;
			return 1'b0;
		end
		if (!in_tok) begin
			if (is_blank(b))
				return 1'b0;
			if (b == CH_HASH) begin
				in_cmt = 1'b1;
				return 1'b0;
			end
			in_tok = 1'b1;
			if (ph == PH_NUMBERS && b == CH_MINUS) begin
				dig_done = 1'b1;
				accum    = 0;
				return 1'b0;
			end
			take_char(b, 1'b1);
			return 1'b0;
		end
		if (is_blank(b))
			return close_token(1'b0, b == CH_CR, r);
		take_char(b, 1'b0);
		return 1'b0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
		$display("%t mismatch on %s: got %0h, want %0h", $realtime, what, seen, wanted);
		mismatch_cnt++;
	endtask

	task automatic check_field(string what, logic [63:0] seen, logic [63:0] wanted);
		if (seen !== wanted)
			report_mismatch(what, seen, wanted);
	endtask

	always @(posedge clk) begin
		res_t want;
		res_t pred;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with none due", 64'(m_axis_tdata), '0);
				end else begin
					want = expected_words.pop_front();
					check_field("kind", 64'(m_axis_tuser[1:0]), 64'(want.kind));
					check_field("pixel_data", 64'(m_axis_tdata[7:0]), 64'(want.pixel_data));
					check_field("channel", 64'(m_axis_tuser[3:2]), 64'(want.channel));
					check_field("image_width", 64'(m_axis_tdata[23:8]),
						64'(want.image_width));
					check_field("image_height", 64'(m_axis_tdata[39:24]),
						64'(want.image_height));
					check_field("max_value", 64'(m_axis_tdata[47:40]), 64'(want.max_value));
					check_field("error_code", 64'(m_axis_tdata[50:48]),
						64'(want.error_code));
					check_field("zero fill", 64'(m_axis_tdata[55:51]), '0);
					check_field("last_pixel", 64'(m_axis_tlast), 64'(want.last_pixel));
					if (want.kind == KIND_PIX)
						pix_cnt++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (parse_ppm_byte(s_axis_tdata, s_axis_tuser, pred))
					expected_words.push_back(pred);
			end
			due_cnt = expected_words.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds the p6 parser one ppm file: a header with a comment, mixed blanks,
// a plus sign, leading zeros and junk after the digits, then the pixel
// bytes and a tail of bytes and end marks that must be dropped. Sender and
// receiver idle at random in changing mixes, with one long receiver
// hold-off; a checker module predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ppmp_pkg::*;

	localparam int DIM_BITS    = 16;
	localparam int CYCLE_LIMIT = 60000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AFTER  = 150;

	typedef struct {
		logic [7:0] b;
		logic       eof;
	} file_item_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int fails;
	int outstanding;
	int pixel_words;

	file_item_t ppm_file [$];
	int         sent      = 0;
	int         cycle_cnt = 0;
	int         img_w;
	int         img_h;
	int         img_max;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	ppm_p6_stream_parser #(
		.DIM_BITS(DIM_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	ppm_p6_checker #(
		.DIM_BITS(DIM_BITS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.fails        (fails),
		.outstanding  (outstanding),
		.pixel_words  (pixel_words)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (s_axis_tvalid && s_axis_tready)
			sent <= sent + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// idle mix per third of the file: sender light, then receiver light, then none
	function automatic int idle_pct(bit rx);
		int stage;
		stage = (sent * 3) / ppm_file.size();
		if (stage == 0)
			return rx ? 59 : 17;
		if (stage == 1)
			return rx ? 17 : 59;
		return 0;
	endfunction

	task automatic push_byte(logic [7:0] b, logic eof = 1'b0);
		file_item_t it;
		it.b   = b;
		it.eof = eof;
		ppm_file.push_back(it);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic build_file();
		logic [7:0] blanks [4];
		logic [7:0] delim;
		blanks  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
		img_w   = $urandom_range(24, 1);
		img_h   = 200 / img_w;
		case ($urandom_range(2))
			0:       img_max = MAXVAL_LIM;
			1:       img_max = 1;
			default: img_max = $urandom_range(254, 2);
		endcase
		push_text("P6");
		push_byte(CH_LF);
		push_text("# c\r");
		push_byte(CH_LF);
		push_byte(CH_TAB);
		push_byte(CH_PLUS);
		push_text($sformatf("00%0d", img_w));
		// a hash inside a token is just another character
		push_text("x#");
		push_byte(CH_SPACE);
		push_text($sformatf("0%0d", img_h));
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_text($sformatf("%0d", img_max));
		delim = blanks[2'($urandom_range(3))];
		if ($urandom_range(1))
			delim = CH_CR;
		push_byte(delim);
		if (delim == CH_CR && $urandom_range(1))
			push_byte(CH_LF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_LF);
		for (int i = 3; i < img_w * img_h * 3; i++)
			push_byte(8'($urandom_range(255)));
		// tail after the image is dropped
		push_byte(8'($urandom_range(255)), 1'b1);
		for (int i = 0; i < 11; i++)
			push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	initial begin
		int rx_words;
		bit held;
		rx_words = 0;
		held     = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				rx_words++;
			if (!held && rx_words >= HOLD_AFTER) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	initial begin
		build_file();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (ppm_file[i]) begin
			while ($urandom_range(99) < idle_pct(1'b0)) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= ppm_file[i].b;
			s_axis_tuser  <= ppm_file[i].eof;
			do
				@(posedge clk);
			while (!s_axis_tready);
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		$display("covered one %0dx%0d image with maxval %0d: %0d input words, %0d pixel words",
			img_w, img_h, img_max, ppm_file.size(), pixel_words);
		$display("mismatches seen: %0d", fails);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
